// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files; the window block includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- rtl/mlw_pkg.sv -----
// ---------------------------------------------------------------------------
// mlw_pkg
// Constants and types of the minimum-length window block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlw_pkg;

    // Ring depth; must be a power of two so that pointers wrap naturally.
    localparam int DEPTH       = 1024;
    localparam int VALUE_WIDTH = 16;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = PTR_W + 1;
    localparam int TARGET_W    = 26;
    localparam int TOTAL_W     = VALUE_WIDTH + PTR_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_APPEND,
        ST_CHECK,
        ST_DROP,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/mlw_ram.sv -----
// ---------------------------------------------------------------------------
// mlw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlw_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/min_length_window_reaching_sum.sv -----
// ---------------------------------------------------------------------------
// min_length_window_reaching_sum
// Shortest window of a value stream whose sum reaches a configured target.
// ---------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  s_       in   s_valid / s_ready     s_value[15:0], s_first
//  m_       out  m_valid / m_ready     m_best_len[10:0], m_overflow
//  cfg_     in   cfg_valid / cfg_ready cfg_data[25:0] (target_sum)
//
//  A word is accepted in IDLE and checked in CHECK; each oldest value dropped
//  while it is processed adds a DROP and another CHECK, and a full ring adds
//  EVICT and APPEND first. Every drop is a RAM read followed by one pass
//  through the shared add/subtract unit. Over a long stream each value is
//  dropped at most once. s_ready is high only while the sequencer is idle.
//  A finished result waits in the output register; a stalled m_ready holds
//  the next result in the sequencer. Reset needs no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module min_length_window_reaching_sum
    import mlw_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [VALUE_WIDTH-1:0] s_value,
    input  wire logic                   s_first,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [CNT_W-1:0]       m_best_len,
    output logic                        m_overflow,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [TARGET_W-1:0]    cfg_data
);

    state_t state_reg, state_next;

    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]       short_reg, short_next;
    logic                   ovf_reg, ovf_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [TARGET_W-1:0]    target_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]       best_reg, best_next;
    logic                   out_ovf_reg, out_ovf_next;

    logic                   ram_wr_en, ram_rd_en;
    logic [PTR_W-1:0]       ram_wr_addr, ram_rd_addr;
    logic [VALUE_WIDTH-1:0] ram_wr_data, ram_rd_data;

    logic                   accept, out_free, hit;
    logic                   alu_sub;
    logic [TOTAL_W-1:0]     alu_a, alu_b, alu_y;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_best_len = best_reg;
    assign m_overflow = out_ovf_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign hit        = (count_reg != '0) && (total_reg >= TOTAL_W'(target_reg));

    // The shared adder of the window sum: appends add a value, drops and evictions subtract one.
    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    mlw_ram #(
        .DATA_W(VALUE_WIDTH),
        .ADDR_W(PTR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_first && (count_reg == CNT_W'(DEPTH))) begin
                        state_next = ST_EVICT;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_EVICT:  state_next = ST_APPEND;
            ST_APPEND: state_next = ST_CHECK;
            ST_CHECK: begin
                if (hit) begin
                    state_next = ST_DROP;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DROP: state_next = ST_CHECK;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ptr_next     = ptr_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        short_next   = short_reg;
        ovf_next     = ovf_reg;
        val_next     = val_reg;
        best_next    = best_reg;
        out_ovf_next = out_ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = ptr_reg + count_reg[PTR_W-1:0];
        ram_wr_data  = val_reg;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = ptr_reg;
        alu_sub      = 1'b0;
        alu_a        = total_reg;
        alu_b        = TOTAL_W'(val_reg);
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    val_next = s_value;
                    alu_b    = TOTAL_W'(s_value);
                    if (s_first) begin
                        // A new array starts from an empty window.
                        short_next  = '0;
                        ovf_next    = 1'b0;
                        alu_a       = '0;
                        ptr_next    = '0;
                        ram_wr_addr = '0;
                        ram_wr_en   = 1'b1;
                        ram_wr_data = s_value;
                        count_next  = CNT_W'(1);
                        total_next  = alu_y;
                    end else if (count_reg == CNT_W'(DEPTH)) begin
                        ram_rd_en = 1'b1;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = s_value;
                        count_next  = count_reg + 1'b1;
                        total_next  = alu_y;
                    end
                end
            end
            ST_EVICT: begin
                // A full ring loses its oldest value without a length check.
                alu_sub    = 1'b1;
                alu_b      = TOTAL_W'(ram_rd_data);
                total_next = alu_y;
                ptr_next   = ptr_reg + 1'b1;
                count_next = count_reg - 1'b1;
                ovf_next   = 1'b1;
            end
            ST_APPEND: begin
                ram_wr_en  = 1'b1;
                count_next = count_reg + 1'b1;
                total_next = alu_y;
            end
            ST_CHECK: begin
                if (hit) begin
                    if ((short_reg == '0) || (count_reg < short_reg)) begin
                        short_next = count_reg;
                    end
                    ram_rd_en = 1'b1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    best_next    = short_reg;
                    out_ovf_next = ovf_reg;
                end
            end
            ST_DROP: begin
                alu_sub    = 1'b1;
                alu_b      = TOTAL_W'(ram_rd_data);
                total_next = alu_y;
                ptr_next   = ptr_reg + 1'b1;
                count_next = count_reg - 1'b1;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    best_next    = short_reg;
                    out_ovf_next = ovf_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            short_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            target_reg  <= TARGET_W'(1);
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            short_reg   <= short_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                target_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        best_reg    <= best_next;
        out_ovf_reg <= out_ovf_next;
    end

    `ASSERT_CLK(a_count_bound, count_reg <= CNT_W'(DEPTH), "window count above depth")
    `ASSERT_CLK(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "ready right after a word")
    `ASSERT_CLK(a_drop_nonempty, state_reg == ST_DROP |-> count_reg != '0, "drop from empty window")
    `ASSERT_CLK(a_result_source, $rose(m_valid) |-> $past(state_reg == ST_CHECK || state_reg == ST_OUT), "result outside check")
    `ASSERT_CLK(a_best_bound, m_valid |-> m_best_len <= CNT_W'(DEPTH), "best length above depth")

endmodule

`default_nettype wire

// ----- sim/mlw_window_monitor.sv -----
// ---------------------------------------------------------------------------
// mlw_window_monitor
// Watches the input, result and target ports of the minimum-length window
// block, keeps its own copy of the window state to predict every result, and
// compares each delivered result with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlw_window_monitor
    import mlw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value,
    input  logic                   s_first,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [CNT_W-1:0]       m_best_len,
    input  logic                   m_overflow,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [TARGET_W-1:0]    cfg_data,
    output int                     mismatch_count,
    output int                     outstanding
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [CNT_W-1:0] best_len;
        logic             overflow;
    } window_report_t;

    // Shadow of the block's window.
    logic [VALUE_WIDTH-1:0] ring [DEPTH];
    logic [PTR_W-1:0]       head;
    logic [CNT_W-1:0]       fill;
    logic [TOTAL_W-1:0]     run_sum;
    logic [CNT_W-1:0]       best;
    logic                   ovf_flag;
    logic [TARGET_W-1:0]    target;

    window_report_t expected_reports [$];
    int             errors = 0;
    int             results_seen = 0;

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    function automatic void clear_window();
        head     = '0;
        fill     = '0;
        run_sum  = '0;
        best     = '0;
        ovf_flag = 1'b0;
    endfunction

    function automatic void retire_head();
        run_sum = run_sum - TOTAL_W'(ring[head]);
        head    = head + 1'b1;
        fill    = fill - 1'b1;
    endfunction

    function automatic void absorb_value(input logic [VALUE_WIDTH-1:0] v,
                                         input logic starts,
                                         output window_report_t rep);
        logic [PTR_W-1:0] slot;
        if (starts)
            clear_window();
        // A full ring loses its oldest word without a length being recorded.
        if (fill >= CNT_W'(DEPTH)) begin
            ovf_flag = 1'b1;
            retire_head();
        end
        slot       = head + fill[PTR_W-1:0];
        ring[slot] = v;
        fill       = fill + 1'b1;
        run_sum    = run_sum + TOTAL_W'(v);
        while (fill != 0 && run_sum >= TOTAL_W'(target)) begin
            if (best == 0 || fill < best)
                best = fill;
            retire_head();
        end
        rep.best_len = best;
        rep.overflow = ovf_flag;
    endfunction

    always @(posedge aclk) begin : watch
        window_report_t got_rep;
        window_report_t want;
        if (!aresetn) begin
            clear_window();
            target = TARGET_W'(1);
            expected_reports.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                target = cfg_data;
            if (s_valid && s_ready) begin
                absorb_value(s_value, s_first, got_rep);
                expected_reports.push_back(got_rep);
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with nothing expected",
                                         results_seen));
                end else begin
                    want = expected_reports.pop_front();
                    if (m_best_len !== want.best_len)
                        flag_error($sformatf("result %0d: best_len %0d, expected %0d",
                                             results_seen, m_best_len, want.best_len));
                    if (m_overflow !== want.overflow)
                        flag_error($sformatf("result %0d: overflow %0b, expected %0b",
                                             results_seen, m_overflow, want.overflow));
                end
                results_seen++;
            end
        end
        outstanding    <= expected_reports.size();
        mismatch_count <= errors;
    end

endmodule

// ----- sim/min_length_window_reaching_sum_test.sv -----
// ---------------------------------------------------------------------------
// min_length_window_reaching_sum_test
// Drives value words and target writes into the minimum-length window block
// under several flow-control patterns, while a monitor beside it predicts and
// checks every result; prints the verdict at the end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_length_window_reaching_sum_test
    import mlw_pkg::*;
();

    localparam int                  SETTLE_CYCLES  = 16;
    localparam int                  HOLD_CYCLES    = 300;
    localparam int                  WATCHDOG_LIMIT = 20000;
    localparam logic [TARGET_W-1:0] TARGET_MAX     = '1;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [VALUE_WIDTH-1:0] s_value   = '0;
    logic                   s_first   = 1'b0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [CNT_W-1:0]       m_best_len;
    logic                   m_overflow;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [TARGET_W-1:0]    cfg_data  = '0;

    int                  mismatch_count;
    int                  outstanding;
    int                  stall_pct = 0;
    bit                  hold_req  = 1'b0;
    int                  idle_pct  = 0;
    logic [TARGET_W-1:0] cur_target = TARGET_W'(1);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    min_length_window_reaching_sum dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_first    (s_first),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_best_len (m_best_len),
        .m_overflow (m_overflow),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    mlw_window_monitor monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_first        (s_first),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_best_len     (m_best_len),
        .m_overflow     (m_overflow),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Result side: random stalls, plus a long hold-off whenever hold_req toggles.
    initial begin : receiver
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("min_length_window_reaching_sum_test failed");
        $finish;
    end

    task automatic send_word(input logic [VALUE_WIDTH-1:0] v, input logic f);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct)
                @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_first <= f;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Stops offering words and waits until every predicted result is back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_target(input logic [TARGET_W-1:0] t);
        cfg_valid <= 1'b1;
        cfg_data  <= t;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid  <= 1'b0;
        cur_target = t;
    endtask

    // Arrays of random length whose values are scaled so that windows of a
    // few to a few dozen words reach the target, with some stray words mixed in.
    task automatic send_arrays(input int n_words);
        int                     sent;
        int                     len;
        int                     span;
        longint                 vmax;
        logic [VALUE_WIDTH-1:0] v;
        logic                   f;
        sent = 0;
        while (sent < n_words) begin
            len  = ($urandom_range(7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
            span = $urandom_range(1, 24);
            vmax = 2 * longint'(cur_target) / span;
            if (vmax < 1)
                vmax = 1;
            if (vmax > 65535)
                vmax = 65535;
            for (int i = 0; i < len && sent < n_words; i++) begin
                case ($urandom_range(15))
                    0: v = '0;
                    1: v = '1;
                    2: v = VALUE_WIDTH'($urandom_range(65535));
                    default: v = VALUE_WIDTH'($urandom_range(int'(vmax)));
                endcase
                if (i == 0)
                    f = ($urandom_range(15) != 0);
                else
                    f = ($urandom_range(31) == 0);
                send_word(v, f);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [TARGET_W-1:0] tgt, input int send_idle,
                             input int recv_stall, input int n_words);
        drain();
        write_target(tgt);
        idle_pct  = send_idle;
        stall_pct <= recv_stall;
        send_arrays(n_words);
    endtask

    initial begin : stimulus
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Words before any start flag run on the state left by reset (target 1).
        send_word(16'd0, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'd0, 1'b1);
        send_word(16'd1, 1'b0);
        drain();
        write_target(TARGET_MAX);
        send_word(16'hFFFF, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h8000, 1'b0);
        drain();
        write_target(TARGET_W'(100));
        send_word(16'd40, 1'b1);
        send_word(16'd30, 1'b0);
        send_word(16'd20, 1'b0);
        send_word(16'd10, 1'b0);
        send_word(16'd90, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'd100, 1'b0);
        send_word(16'd99, 1'b1);
        send_word(16'd1, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'd50, 1'b0);
        send_word(16'd50, 1'b0);
        drain();
        write_target(TARGET_W'(1));
        send_word(16'd0, 1'b1);
        send_word(16'd0, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'hAAAA, 1'b0);

        run_phase(TARGET_W'($urandom_range(20, 400000)), 0, 0, 180);
        run_phase(TARGET_W'(1), 71, 0, 120);
        run_phase(TARGET_W'($urandom_range(20, 400000)), 0, 71, 180);

        // Overflow: a long run of tiny words fills the ring, then large words
        // reach the target and a long shrink follows; a new start clears the flag.
        drain();
        write_target(TARGET_W'(2000000));
        idle_pct  = 21;
        stall_pct <= 21;
        send_word(VALUE_WIDTH'($urandom_range(3)), 1'b1);
        repeat (DEPTH + 5) send_word(VALUE_WIDTH'($urandom_range(3)), 1'b0);
        repeat (80) send_word(VALUE_WIDTH'($urandom_range(65535)), 1'b0);
        send_word(VALUE_WIDTH'($urandom_range(65535)), 1'b1);
        repeat (4) send_word(VALUE_WIDTH'($urandom_range(65535)), 1'b0);

        run_phase(TARGET_MAX, 0, 71, 60);

        // Back-pressure: the result side holds off while words are still offered,
        // then the sender waits for every result before going on.
        drain();
        write_target(TARGET_W'($urandom_range(20, 400000)));
        idle_pct  = 0;
        stall_pct <= 0;
        hold_req  <= ~hold_req;
        send_arrays(60);
        drain();
        send_arrays(60);

        drain();
        if (mismatch_count == 0)
            $display("min_length_window_reaching_sum_test passed");
        else
            $display("min_length_window_reaching_sum_test failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mlw_pkg.sv
rtl/mlw_ram.sv
rtl/min_length_window_reaching_sum.sv
sim/mlw_window_monitor.sv
sim/min_length_window_reaching_sum_test.sv
